@@ rtl/core/point_segment_closest_point_defines.svh @@
// Assertion macros for the closest-point block.
`ifndef POINT_SEGMENT_CLOSEST_POINT_DEFINES_SVH
`define POINT_SEGMENT_CLOSEST_POINT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/psc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int U_WIDTH     = 24;
    localparam int DIST_W      = COORD_WIDTH + 1;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int LEN2_W      = 2 * COORD_WIDTH + 1;
    localparam int Q_W         = U_WIDTH + 1;

    // u saturation bounds
    localparam logic signed [U_WIDTH-1:0] U_POS_SAT = {1'b0, {(U_WIDTH-1){1'b1}}};
    localparam logic signed [U_WIDTH-1:0] U_NEG_SAT = {1'b1, {(U_WIDTH-1){1'b0}}};
    localparam logic [Q_W-1:0] RQ_NEG_LIM = Q_W'(1) << (U_WIDTH - 1);
    localparam logic [Q_W-1:0] RQ_POS_LIM = RQ_NEG_LIM - Q_W'(1);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
    } psc_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] closest_x;
        logic signed [COORD_WIDTH-1:0] closest_y;
        logic signed [U_WIDTH-1:0]     position_u;
        logic                          u_saturated;
        logic                          degenerate;
        logic [DIST_W-1:0]             distance;
    } psc_out_t;

    // Per-item context carried alongside the divider
    typedef struct packed {
        psc_in_t                  item;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic                     degen;
        logic                     dneg;
        logic                     past_end;
        logic                     q_ovf;
    } psc_side_t;

    // Result fields carried alongside the square root
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] closest_x;
        logic signed [COORD_WIDTH-1:0] closest_y;
        logic signed [U_WIDTH-1:0]     position_u;
        logic                          u_saturated;
        logic                          degenerate;
    } psc_res_t;

endpackage
`default_nettype wire

@@ rtl/core/psc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module psc_front #(
    parameter int U_FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  psc_pkg::psc_in_t             in_item,
    output logic                         out_valid,
    output psc_pkg::psc_side_t           out_side,
    output logic [psc_pkg::LEN2_W-1:0]   out_rem,
    output logic [psc_pkg::LEN2_W-1:0]   out_den,
    output logic [psc_pkg::Q_W-1:0]      out_nlow
);
    import psc_pkg::*;

    localparam int SHIFT = U_WIDTH - U_FRAC_BITS;

    logic [4:0] vld_reg, vld_next;

    psc_side_t side1_reg, side1_next, side2_reg, side2_next, side3_reg, side3_next;
    psc_side_t side4_reg, side4_next, side5_reg, side5_next;

    logic signed [DIFF_W-1:0] qx1_reg, qx1_next, qy1_reg, qy1_next;
    logic signed [PROD_W-1:0] pqx2_reg, pqx2_next, pqy2_reg, pqy2_next;
    logic signed [PROD_W-1:0] pdx2_reg, pdx2_next, pdy2_reg, pdy2_next;
    logic signed [PROD_W-1:0] dot3_reg, dot3_next;
    logic [LEN2_W-1:0]        len3_reg, len3_next, len4_reg, len4_next;
    logic [LEN2_W-1:0]        mag4_reg, mag4_next;
    logic [LEN2_W-1:0]        rem5_reg, rem5_next, den5_reg, den5_next;
    logic [Q_W-1:0]           nlow5_reg, nlow5_next;

    logic signed [PROD_W-1:0] lsum, negd;
    logic [LEN2_W+Q_W-1:0]    nfull;

    always_comb begin
        vld_next = {vld_reg[3:0], in_valid};

        // stage 1: differences and zero-length test
        side1_next          = '0;
        side1_next.item     = in_item;
        side1_next.dx       = DIFF_W'(in_item.end_x) - DIFF_W'(in_item.start_x);
        side1_next.dy       = DIFF_W'(in_item.end_y) - DIFF_W'(in_item.start_y);
        side1_next.degen    = (in_item.end_x == in_item.start_x) &&
                              (in_item.end_y == in_item.start_y);
        qx1_next = DIFF_W'(in_item.point_x) - DIFF_W'(in_item.start_x);
        qy1_next = DIFF_W'(in_item.point_y) - DIFF_W'(in_item.start_y);

        // stage 2: four products
        side2_next = side1_reg;
        pqx2_next  = qx1_reg * side1_reg.dx;
        pqy2_next  = qy1_reg * side1_reg.dy;
        pdx2_next  = side1_reg.dx * side1_reg.dx;
        pdy2_next  = side1_reg.dy * side1_reg.dy;

        // stage 3: dot product and squared length
        side3_next = side2_reg;
        dot3_next  = pqx2_reg + pqy2_reg;
        lsum       = pdx2_reg + pdy2_reg;
        len3_next  = lsum[LEN2_W-1:0];

        // stage 4: sign and magnitude of the dot product
        side4_next      = side3_reg;
        side4_next.dneg = dot3_reg[PROD_W-1];
        negd            = -dot3_reg;
        mag4_next       = dot3_reg[PROD_W-1] ? negd[LEN2_W-1:0] : dot3_reg[LEN2_W-1:0];
        len4_next       = len3_reg;

        // stage 5: clamp decision and divider operands
        nfull               = {{Q_W{1'b0}}, mag4_reg} << (U_FRAC_BITS + 1);
        rem5_next           = mag4_reg >> SHIFT;
        den5_next           = len4_reg;
        nlow5_next          = nfull[Q_W-1:0];
        side5_next          = side4_reg;
        side5_next.past_end = !side4_reg.dneg && (mag4_reg > len4_reg);
        side5_next.q_ovf    = rem5_next >= len4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side1_next;
            qx1_reg   <= qx1_next;
            qy1_reg   <= qy1_next;
            side2_reg <= side2_next;
            pqx2_reg  <= pqx2_next;
            pqy2_reg  <= pqy2_next;
            pdx2_reg  <= pdx2_next;
            pdy2_reg  <= pdy2_next;
            side3_reg <= side3_next;
            dot3_reg  <= dot3_next;
            len3_reg  <= len3_next;
            side4_reg <= side4_next;
            mag4_reg  <= mag4_next;
            len4_reg  <= len4_next;
            side5_reg <= side5_next;
            rem5_reg  <= rem5_next;
            den5_reg  <= den5_next;
            nlow5_reg <= nlow5_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_side  = side5_reg;
    assign out_rem   = rem5_reg;
    assign out_den   = den5_reg;
    assign out_nlow  = nlow5_reg;

endmodule
`default_nettype wire

@@ rtl/core/psc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage.
module psc_div #(
    parameter int DEN_W = 49,
    parameter int Q_W   = 25,
    parameter int SB_W  = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DEN_W-1:0] in_rem,
    input  logic [DEN_W-1:0] in_den,
    input  logic [Q_W-1:0]   in_nlow,
    input  logic [SB_W-1:0]  in_sb,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_quo,
    output logic [SB_W-1:0]  out_sb
);
    logic             vld_reg  [Q_W];
    logic [DEN_W-1:0] rem_reg  [Q_W];
    logic [DEN_W-1:0] den_reg  [Q_W];
    logic [Q_W-1:0]   nlow_reg [Q_W];
    logic [Q_W-1:0]   quo_reg  [Q_W];
    logic [SB_W-1:0]  sb_reg   [Q_W];

    logic             src_vld  [Q_W];
    logic [DEN_W-1:0] src_rem  [Q_W];
    logic [DEN_W-1:0] src_den  [Q_W];
    logic [Q_W-1:0]   src_nlow [Q_W];
    logic [Q_W-1:0]   src_quo  [Q_W];
    logic [SB_W-1:0]  src_sb   [Q_W];

    logic [DEN_W:0]   trial    [Q_W];
    logic [DEN_W:0]   diff     [Q_W];
    logic             ge       [Q_W];
    logic [DEN_W-1:0] rem_next [Q_W];
    logic [Q_W-1:0]   nlow_next[Q_W];
    logic [Q_W-1:0]   quo_next [Q_W];

    // stage inputs: port for the first, previous register for the rest
    always_comb begin
        src_vld[0]  = in_valid;
        src_rem[0]  = in_rem;
        src_den[0]  = in_den;
        src_nlow[0] = in_nlow;
        src_quo[0]  = '0;
        src_sb[0]   = in_sb;
        for (int k = 1; k < Q_W; k++) begin
            src_vld[k]  = vld_reg[k-1];
            src_rem[k]  = rem_reg[k-1];
            src_den[k]  = den_reg[k-1];
            src_nlow[k] = nlow_reg[k-1];
            src_quo[k]  = quo_reg[k-1];
            src_sb[k]   = sb_reg[k-1];
        end
    end

    // shift in one numerator bit, trial subtract
    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            trial[k]     = {src_rem[k], src_nlow[k][Q_W-1]};
            diff[k]      = trial[k] - {1'b0, src_den[k]};
            ge[k]        = trial[k] >= {1'b0, src_den[k]};
            rem_next[k]  = ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
            nlow_next[k] = src_nlow[k] << 1;
            quo_next[k]  = {src_quo[k][Q_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < Q_W; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k < Q_W; k++) begin
                vld_reg[k] <= src_vld[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < Q_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= src_den[k];
                nlow_reg[k] <= nlow_next[k];
                quo_reg[k]  <= quo_next[k];
                sb_reg[k]   <= src_sb[k];
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_sb    = sb_reg[Q_W-1];

endmodule
`default_nettype wire

@@ rtl/core/psc_clamp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module psc_clamp #(
    parameter int U_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [psc_pkg::Q_W-1:0]       in_quo,
    input  psc_pkg::psc_side_t            in_side,
    output logic                          out_valid,
    output logic [2*psc_pkg::DIST_W-1:0]  out_rad,
    output psc_pkg::psc_res_t             out_res
);
    import psc_pkg::*;

    localparam int MUL_W = COORD_WIDTH + Q_W;
    localparam logic [MUL_W:0] ROUND_HALF = (MUL_W + 1)'(1) << (U_FRAC_BITS - 1);

    logic [5:0] vld_reg, vld_next;

    psc_side_t side1_reg, side1_next, side2_reg, side2_next, side3_reg, side3_next;
    logic [Q_W-1:0]              rq1_reg, rq1_next;
    logic signed [U_WIDTH-1:0]   u1_reg, u1_next, u2_reg, u2_next;
    logic                        sat1_reg, sat1_next, sat2_reg, sat2_next;
    logic [COORD_WIDTH-1:0]      adx1_reg, adx1_next, ady1_reg, ady1_next;
    logic [MUL_W-1:0]            mx2_reg, mx2_next, my2_reg, my2_next;
    psc_res_t res3_reg, res3_next, res4_reg, res4_next, res5_reg, res5_next;
    psc_res_t res6_reg, res6_next;
    logic signed [DIFF_W-1:0]    ax4_reg, ax4_next, ay4_reg, ay4_next;
    logic signed [PROD_W-1:0]    sqx5_reg, sqx5_next, sqy5_reg, sqy5_next;
    logic [2*DIST_W-1:0]         rad6_reg, rad6_next;

    logic [Q_W:0]             qp1;
    logic [Q_W-1:0]           nrq;
    logic signed [DIFF_W-1:0] ndx, ndy;
    logic [MUL_W:0]           ox_full, oy_full;
    logic [DIFF_W-1:0]        ox, oy, sxe, sye, intx, inty;
    logic signed [PROD_W-1:0] rsum;

    always_comb begin
        vld_next = {vld_reg[4:0], in_valid};

        // stage 1: round u, saturate, axis magnitudes
        side1_next = in_side;
        qp1        = {1'b0, in_quo} + (Q_W + 1)'(1);
        rq1_next   = qp1[Q_W:1];
        nrq        = -rq1_next;
        if (in_side.degen) begin
            u1_next   = '0;
            sat1_next = 1'b0;
        end else if (in_side.dneg) begin
            sat1_next = in_side.q_ovf || (rq1_next > RQ_NEG_LIM);
            u1_next   = sat1_next ? U_NEG_SAT : nrq[U_WIDTH-1:0];
        end else begin
            sat1_next = in_side.q_ovf || (rq1_next > RQ_POS_LIM);
            u1_next   = sat1_next ? U_POS_SAT : rq1_next[U_WIDTH-1:0];
        end
        ndx       = -in_side.dx;
        ndy       = -in_side.dy;
        adx1_next = in_side.dx[DIFF_W-1] ? ndx[COORD_WIDTH-1:0] : in_side.dx[COORD_WIDTH-1:0];
        ady1_next = in_side.dy[DIFF_W-1] ? ndy[COORD_WIDTH-1:0] : in_side.dy[COORD_WIDTH-1:0];

        // stage 2: offset products
        side2_next = side1_reg;
        u2_next    = u1_reg;
        sat2_next  = sat1_reg;
        mx2_next   = MUL_W'(adx1_reg) * MUL_W'(rq1_reg);
        my2_next   = MUL_W'(ady1_reg) * MUL_W'(rq1_reg);

        // stage 3: round offsets, pick start, end or interior point
        side3_next = side2_reg;
        ox_full    = {1'b0, mx2_reg} + ROUND_HALF;
        oy_full    = {1'b0, my2_reg} + ROUND_HALF;
        ox         = DIFF_W'(ox_full >> U_FRAC_BITS);
        oy         = DIFF_W'(oy_full >> U_FRAC_BITS);
        sxe        = DIFF_W'(side2_reg.item.start_x);
        sye        = DIFF_W'(side2_reg.item.start_y);
        intx       = side2_reg.dx[DIFF_W-1] ? sxe - ox : sxe + ox;
        inty       = side2_reg.dy[DIFF_W-1] ? sye - oy : sye + oy;
        res3_next.position_u  = u2_reg;
        res3_next.u_saturated = sat2_reg;
        res3_next.degenerate  = side2_reg.degen;
        if (side2_reg.degen || side2_reg.dneg) begin
            res3_next.closest_x = side2_reg.item.start_x;
            res3_next.closest_y = side2_reg.item.start_y;
        end else if (side2_reg.past_end) begin
            res3_next.closest_x = side2_reg.item.end_x;
            res3_next.closest_y = side2_reg.item.end_y;
        end else begin
            res3_next.closest_x = intx[COORD_WIDTH-1:0];
            res3_next.closest_y = inty[COORD_WIDTH-1:0];
        end

        // stage 4: point minus closest point
        res4_next = res3_reg;
        ax4_next  = DIFF_W'(side3_reg.item.point_x) - DIFF_W'(res3_reg.closest_x);
        ay4_next  = DIFF_W'(side3_reg.item.point_y) - DIFF_W'(res3_reg.closest_y);

        // stage 5: squares
        res5_next = res4_reg;
        sqx5_next = ax4_reg * ax4_reg;
        sqy5_next = ay4_reg * ay4_reg;

        // stage 6: squared distance
        res6_next = res5_reg;
        rsum      = sqx5_reg + sqy5_reg;
        rad6_next = rsum[2*DIST_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side1_next;
            rq1_reg   <= rq1_next;
            u1_reg    <= u1_next;
            sat1_reg  <= sat1_next;
            adx1_reg  <= adx1_next;
            ady1_reg  <= ady1_next;
            side2_reg <= side2_next;
            u2_reg    <= u2_next;
            sat2_reg  <= sat2_next;
            mx2_reg   <= mx2_next;
            my2_reg   <= my2_next;
            side3_reg <= side3_next;
            res3_reg  <= res3_next;
            res4_reg  <= res4_next;
            ax4_reg   <= ax4_next;
            ay4_reg   <= ay4_next;
            res5_reg  <= res5_next;
            sqx5_reg  <= sqx5_next;
            sqy5_reg  <= sqy5_next;
            res6_reg  <= res6_next;
            rad6_reg  <= rad6_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_rad   = rad6_reg;
    assign out_res   = res6_reg;

endmodule
`default_nettype wire

@@ rtl/core/psc_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Digit-by-digit square root, one root bit per stage, then round to nearest.
module psc_sqrt #(
    parameter int STEPS = 25,
    parameter int SB_W  = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [2*STEPS-1:0] in_rad,
    input  logic [SB_W-1:0]    in_sb,
    output logic               out_valid,
    output logic [STEPS-1:0]   out_root,
    output logic [SB_W-1:0]    out_sb
);
    localparam int RW = STEPS + 1;

    logic               vld_reg  [STEPS];
    logic [RW-1:0]      rem_reg  [STEPS];
    logic [2*STEPS-1:0] rad_reg  [STEPS];
    logic [STEPS-1:0]   root_reg [STEPS];
    logic [SB_W-1:0]    sb_reg   [STEPS];

    logic               src_vld  [STEPS];
    logic [RW-1:0]      src_rem  [STEPS];
    logic [2*STEPS-1:0] src_rad  [STEPS];
    logic [STEPS-1:0]   src_root [STEPS];
    logic [SB_W-1:0]    src_sb   [STEPS];

    logic [RW+1:0]      trial    [STEPS];
    logic [RW+1:0]      tsub     [STEPS];
    logic [RW+1:0]      diff     [STEPS];
    logic               ge       [STEPS];
    logic [RW-1:0]      rem_next [STEPS];
    logic [2*STEPS-1:0] rad_next [STEPS];
    logic [STEPS-1:0]   root_next[STEPS];

    logic               fin_vld_reg;
    logic [STEPS-1:0]   dist_reg, dist_next;
    logic [SB_W-1:0]    fin_sb_reg;

    always_comb begin
        src_vld[0]  = in_valid;
        src_rem[0]  = '0;
        src_rad[0]  = in_rad;
        src_root[0] = '0;
        src_sb[0]   = in_sb;
        for (int k = 1; k < STEPS; k++) begin
            src_vld[k]  = vld_reg[k-1];
            src_rem[k]  = rem_reg[k-1];
            src_rad[k]  = rad_reg[k-1];
            src_root[k] = root_reg[k-1];
            src_sb[k]   = sb_reg[k-1];
        end
    end

    // bring down two radicand bits, try root bit one
    always_comb begin
        for (int k = 0; k < STEPS; k++) begin
            trial[k]     = {src_rem[k], src_rad[k][2*STEPS-1 -: 2]};
            tsub[k]      = {1'b0, src_root[k], 2'b01};
            diff[k]      = trial[k] - tsub[k];
            ge[k]        = trial[k] >= tsub[k];
            rem_next[k]  = ge[k] ? diff[k][RW-1:0] : trial[k][RW-1:0];
            rad_next[k]  = src_rad[k] << 2;
            root_next[k] = {src_root[k][STEPS-2:0], ge[k]};
        end
    end

    // remainder above root means the value lies past the midpoint
    assign dist_next = root_reg[STEPS-1] +
                       STEPS'(rem_reg[STEPS-1] > {1'b0, root_reg[STEPS-1]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STEPS; k++) begin
                vld_reg[k] <= 1'b0;
            end
            fin_vld_reg <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < STEPS; k++) begin
                vld_reg[k] <= src_vld[k];
            end
            fin_vld_reg <= vld_reg[STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < STEPS; k++) begin
                rem_reg[k]  <= rem_next[k];
                rad_reg[k]  <= rad_next[k];
                root_reg[k] <= root_next[k];
                sb_reg[k]   <= src_sb[k];
            end
            dist_reg   <= dist_next;
            fin_sb_reg <= sb_reg[STEPS-1];
        end
    end

    assign out_valid = fin_vld_reg;
    assign out_root  = dist_reg;
    assign out_sb    = fin_sb_reg;

endmodule
`default_nettype wire

@@ rtl/core/point_segment_closest_point.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Closest point on a 2-D segment. Each item carries a query point and a
// segment (start, end) in signed Q15.8; the result gives the clamped closest
// point, the unclamped parameter u in signed Q(23-U_FRAC_BITS).U_FRAC_BITS
// (rounded, then saturated with a flag), a zero-length flag and the rounded
// Euclidean distance. The block is a fixed pipeline that takes one item per
// clock while the output item is not held; u comes from a one-bit-per-stage
// divider and the distance from a one-bit-per-stage square root.
// All stages advance together whenever the output register is empty or
// m_ready is high, so s_ready follows that condition.
module point_segment_closest_point #(
    parameter int U_FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  psc_pkg::psc_in_t   s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output psc_pkg::psc_out_t  m_item
);
    import psc_pkg::*;

    localparam int SIDE_W = $bits(psc_side_t);
    localparam int RES_W  = $bits(psc_res_t);

    logic                en;
    logic                fr_valid, dv_valid, cl_valid;
    psc_side_t           fr_side, dv_side;
    logic [LEN2_W-1:0]   fr_rem, fr_den;
    logic [Q_W-1:0]      fr_nlow, dv_quo;
    logic [SIDE_W-1:0]   dv_sb;
    logic [2*DIST_W-1:0] cl_rad;
    psc_res_t            cl_res, sq_res;
    logic [RES_W-1:0]    sq_sb;
    logic [DIST_W-1:0]   sq_root;

    // whole pipeline moves unless the output item is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    psc_front #(.U_FRAC_BITS(U_FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_item   (s_item),
        .out_valid (fr_valid),
        .out_side  (fr_side),
        .out_rem   (fr_rem),
        .out_den   (fr_den),
        .out_nlow  (fr_nlow)
    );

    psc_div #(.DEN_W(LEN2_W), .Q_W(Q_W), .SB_W(SIDE_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_rem    (fr_rem),
        .in_den    (fr_den),
        .in_nlow   (fr_nlow),
        .in_sb     (fr_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_sb    (dv_sb)
    );

    assign dv_side = psc_side_t'(dv_sb);

    psc_clamp #(.U_FRAC_BITS(U_FRAC_BITS)) u_clamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .in_quo    (dv_quo),
        .in_side   (dv_side),
        .out_valid (cl_valid),
        .out_rad   (cl_rad),
        .out_res   (cl_res)
    );

    psc_sqrt #(.STEPS(DIST_W), .SB_W(RES_W)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cl_valid),
        .in_rad    (cl_rad),
        .in_sb     (cl_res),
        .out_valid (m_valid),
        .out_root  (sq_root),
        .out_sb    (sq_sb)
    );

    // result item
    always_comb begin
        sq_res             = psc_res_t'(sq_sb);
        m_item.closest_x   = sq_res.closest_x;
        m_item.closest_y   = sq_res.closest_y;
        m_item.position_u  = sq_res.position_u;
        m_item.u_saturated = sq_res.u_saturated;
        m_item.degenerate  = sq_res.degenerate;
        m_item.distance    = sq_root;
    end

endmodule
`default_nettype wire

@@ rtl/core/psc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "point_segment_closest_point_defines.svh"
module psc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input psc_pkg::psc_out_t m_item
);
    import psc_pkg::*;

    // a held result item keeps its payload
    `PSC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item), "result item changed while stalled")

    // an empty output stage never blocks the input
    `PSC_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "input stalled with empty output")

    // zero-length segment reports u of zero, unsaturated
    `PSC_ASSERT_IMPL(a_degen_u, aclk, aresetn, m_valid && m_item.degenerate, (m_item.position_u == '0) && !m_item.u_saturated, "zero-length segment with nonzero u")

    // saturated u sits on a range limit
    `PSC_ASSERT_IMPL(a_sat_limit, aclk, aresetn, m_valid && m_item.u_saturated, (m_item.position_u == U_POS_SAT) || (m_item.position_u == U_NEG_SAT), "saturated u off its limit")

endmodule

bind point_segment_closest_point psc_checker u_psc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
`default_nettype wire
